/* rtl/core/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpw assertion failed");

// next-cycle implication, disabled during reset
`define LPW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpw assertion failed");

// next-cycle implication that also runs through reset
`define LPW_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lpw assertion failed");

`endif

/* rtl/core/lpw_pkg.sv */
// ----------------------------------------------------------------------------
// lpw_pkg
// Shared constants and codes of the local path window extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package lpw_pkg;

    localparam int PATH_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int CMD_W        = 2;
    localparam int RANGE_W      = 16;
    localparam int FOLLOW_LEN_W = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 21;

    // squared distance below which the robot counts as on the path
    localparam logic [31:0] REACHED_SQ_MM = 32'd50000;

    localparam logic [RANGE_W-1:0]      IGNORE_BACK_RST = 16'd1000;
    localparam logic [RANGE_W-1:0]      FOLLOW_RANGE_RST = 16'd3000;
    localparam logic [FOLLOW_LEN_W-1:0] FOLLOW_LEN_RST = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_PLAN   = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IGNORE_BACK  = 2'd0,
        CFG_FOLLOW_RANGE = 2'd1,
        CFG_FOLLOW_LEN   = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

/* rtl/core/lpw_isqrt.sv */
// ----------------------------------------------------------------------------
// lpw_isqrt
// Integer square root, rounded down, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpw_isqrt #(
    parameter int IN_W = 51
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [IN_W-1:0]         value,
    output logic                         done,
    output logic [(IN_W+1)/2-1:0]        root
);

    localparam int ROOT_W = (IN_W + 1) / 2;
    localparam int BIT_W  = 2 * ROOT_W;
    localparam int RES_W  = BIT_W + 1;

    logic [BIT_W-1:0] rem_reg;
    logic [RES_W-1:0] res_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RES_W-1:0] trial;

    assign trial = res_reg + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= BIT_W'(value);
                res_reg  <= '0;
                bit_reg  <= BIT_W'(1) << (BIT_W - 2);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg <= BIT_W'({1'b0, rem_reg} - trial);
                    res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/local_path_window_extract.sv */
// ----------------------------------------------------------------------------
// local_path_window_extract
// Path point ring with prune, nearest-point search and local window output.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser: cmd, tdata: pos_x, pos_y
//  m_      | out | m_tvalid/m_tready  | tdata: out_x, out_y, tlast: is_last,
//          |     |                    | tuser: is_empty
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
//  Clear, append and unknown commands are taken in the idle state.
//  A plan squares the two ranges, checks points in the prune and searches
//  points, then per emitted word forms the distance to the robot and, when a
//  segment length is accumulated, a square root, or sends the empty word; the
//  shared squarer and the square root unit do this, and m_tready stalls hold it.
//  Reset is synchronous and needs no clearing pass; the path store is
//  read only below the point count.
//  A waiting result does not block the sequencer until the next one is due.
// ----------------------------------------------------------------------------
`default_nettype none

module local_path_window_extract #(
    parameter int PATH_DEPTH = lpw_pkg::PATH_DEPTH_DEF,
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // config
    input  wire logic                                 cfg_we,
    input  wire logic [lpw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [lpw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input words
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // pos_x, pos_y, zero pad
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // cmd
    input  wire logic [lpw_pkg::CMD_W-1:0]            s_tuser,
    // result words
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // out_x, out_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_tdata,
    // is_last
    output logic                                      m_tlast,
    // is_empty
    output logic                                      m_tuser
);

    import lpw_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int TDATA_W = ((2 * C + 7) / 8) * 8;
    localparam int IDX_W   = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CNT_W   = $clog2(PATH_DEPTH + 1);
    localparam int DIFF_W  = C + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int SQRT_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int ROOT_W  = (SQRT_W + 1) / 2;
    localparam int LEN_W   = (ROOT_W + CNT_W > FOLLOW_LEN_W) ? ROOT_W + CNT_W : FOLLOW_LEN_W;

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_SQ_IG  = 22'h000002,
        ST_SQ_TH  = 22'h000004,
        ST_PR_RD  = 22'h000008,
        ST_PR_LD  = 22'h000010,
        ST_PR_CHK = 22'h000020,
        ST_SR_INI = 22'h000040,
        ST_SR_RD  = 22'h000080,
        ST_SR_LD  = 22'h000100,
        ST_SR_CHK = 22'h000200,
        ST_EX_BEG = 22'h000400,
        ST_EX_RD  = 22'h000800,
        ST_EX_LD  = 22'h001000,
        ST_EX_D1  = 22'h002000,
        ST_EX_PRD = 22'h004000,
        ST_EX_PLD = 22'h008000,
        ST_EX_D2  = 22'h010000,
        ST_EX_SQ  = 22'h020000,
        ST_EX_OUT = 22'h040000,
        ST_EMPTY  = 22'h080000,
        ST_D_X    = 22'h100000,
        ST_D_Y    = 22'h200000
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    logic [RANGE_W-1:0]      ignore_reg;
    logic [RANGE_W-1:0]      range_reg;
    logic [FOLLOW_LEN_W-1:0] flen_reg;

    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] best_k_reg;

    logic [2*C-1:0] mem [PATH_DEPTH];
    logic [2*C-1:0] mem_q_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [C-1:0] rob_x_reg, rob_y_reg;
    logic [C-1:0] cur_x_reg, cur_y_reg;
    logic [C-1:0] prev_x_reg, prev_y_reg;
    logic         use_prev_reg;

    logic [31:0]      ig_sq_reg, th_sq_reg;
    logic [SQ_W-1:0]  prod_x_reg;
    logic [SUM_W-1:0] dist_reg;
    logic [SUM_W-1:0] best_reg;
    logic [SUM_W-1:0] drob_reg;
    logic             reached_reg;
    logic [LEN_W-1:0] plen_reg;

    logic           m_valid_reg;
    logic [C-1:0]   out_x_reg, out_y_reg;
    logic           last_reg, empty_reg;

    logic [DIFF_W-1:0] mul_op;
    logic [SQ_W-1:0]   prod;
    logic [C-1:0]      b_x, b_y;
    logic [DIFF_W-1:0] dx, dy, adx, ady;
    logic [SUM_W-1:0]  dist_now;
    logic [SUM_W-1:0]  dist_sat;
    logic [SQRT_W-1:0] sqrt_in;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              s_acc;
    logic              out_free;
    logic              out_load;
    logic              len_neg, len_pos;
    logic              cont;
    logic [LEN_W-1:0]  flen_mag;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(head) + (CNT_W + 1)'(k);
        if (s >= (CNT_W + 1)'(PATH_DEPTH))
            s = s - (CNT_W + 1)'(PATH_DEPTH);
        return IDX_W'(s);
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && (state_reg == ST_EX_OUT || state_reg == ST_EMPTY);
    assign len_neg  = flen_reg[FOLLOW_LEN_W-1];
    assign len_pos  = !len_neg && (flen_reg != '0);
    assign flen_mag = LEN_W'(flen_reg[FOLLOW_LEN_W-2:0]);

    // distance datapath: one shared squarer
    assign b_x = use_prev_reg ? prev_x_reg : rob_x_reg;
    assign b_y = use_prev_reg ? prev_y_reg : rob_y_reg;
    assign dx  = {cur_x_reg[C-1], cur_x_reg} - {b_x[C-1], b_x};
    assign dy  = {cur_y_reg[C-1], cur_y_reg} - {b_y[C-1], b_y};
    assign adx = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    assign ady = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;

    always_comb begin
        case (state_reg)
            ST_SQ_IG: mul_op = DIFF_W'(ignore_reg);
            ST_SQ_TH: mul_op = DIFF_W'(range_reg);
            ST_D_X:   mul_op = adx;
            ST_D_Y:   mul_op = ady;
            default:  mul_op = '0;
        endcase
    end

    assign prod     = SQ_W'(mul_op) * SQ_W'(mul_op);
    assign dist_now = SUM_W'(prod_x_reg) + SUM_W'(prod);

    // squared distances saturate at 64 bits for wide coordinates
    assign dist_sat = (SUM_W > 64 && dist_now > SUM_W'(64'hFFFF_FFFF_FFFF_FFFF))
                    ? SUM_W'(64'hFFFF_FFFF_FFFF_FFFF) : dist_now;

    assign sqrt_in = dist_reg[SQRT_W-1:0];

    assign cont = (CNT_W'(k_reg + CNT_W'(1)) < count_reg)
               && (drob_reg <= SUM_W'(th_sq_reg))
               && (len_neg || plen_reg < flen_mag);

    always_comb begin
        if (state_reg == ST_EX_PRD)
            rd_addr = slot_of(head_reg, CNT_W'(k_reg - CNT_W'(1)));
        else
            rd_addr = slot_of(head_reg, k_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == CMD_APPEND && count_reg < CNT_W'(PATH_DEPTH))
            mem[slot_of(head_reg, count_reg)] <= s_tdata[2*C-1:0];
        mem_q_reg <= mem[rd_addr];
    end

    lpw_isqrt #(.IN_W(SQRT_W)) u_lpw_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_EX_D2),
        .value   (sqrt_in),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            ignore_reg  <= IGNORE_BACK_RST;
            range_reg   <= FOLLOW_RANGE_RST;
            flen_reg    <= FOLLOW_LEN_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IGNORE_BACK:  ignore_reg <= cfg_wdata[RANGE_W-1:0];
                    CFG_FOLLOW_RANGE: range_reg  <= cfg_wdata[RANGE_W-1:0];
                    CFG_FOLLOW_LEN:   flen_reg   <= cfg_wdata[FOLLOW_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready && !out_load)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_tuser)
                            CMD_CLEAR: begin
                                head_reg  <= '0;
                                count_reg <= '0;
                            end
                            CMD_APPEND: begin
                                if (count_reg < CNT_W'(PATH_DEPTH))
                                    count_reg <= count_reg + CNT_W'(1);
                            end
                            CMD_PLAN: begin
                                rob_x_reg <= s_tdata[C-1:0];
                                rob_y_reg <= s_tdata[2*C-1:C];
                                state_reg <= ST_SQ_IG;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SQ_IG: begin
                    ig_sq_reg <= prod[31:0];
                    state_reg <= ST_SQ_TH;
                end
                ST_SQ_TH: begin
                    th_sq_reg <= prod[31:0];
                    k_reg     <= '0;
                    state_reg <= (count_reg > CNT_W'(1)) ? ST_PR_RD : ST_SR_INI;
                end
                ST_PR_RD: state_reg <= ST_PR_LD;
                ST_PR_LD: begin
                    cur_x_reg    <= mem_q_reg[C-1:0];
                    cur_y_reg    <= mem_q_reg[2*C-1:C];
                    use_prev_reg <= 1'b0;
                    ret_reg      <= ST_PR_CHK;
                    state_reg    <= ST_D_X;
                end
                ST_PR_CHK: begin
                    if (dist_reg < SUM_W'(ig_sq_reg)) begin
                        head_reg  <= slot_of(head_reg, k_reg);
                        count_reg <= count_reg - k_reg;
                        state_reg <= ST_SR_INI;
                    end else if (CNT_W'(k_reg + CNT_W'(1)) == count_reg) begin
                        state_reg <= ST_SR_INI;
                    end else begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= ST_PR_RD;
                    end
                end
                ST_SR_INI: begin
                    k_reg     <= '0;
                    state_reg <= (count_reg == '0) ? ST_EMPTY : ST_SR_RD;
                end
                ST_SR_RD: state_reg <= ST_SR_LD;
                ST_SR_LD: begin
                    cur_x_reg    <= mem_q_reg[C-1:0];
                    cur_y_reg    <= mem_q_reg[2*C-1:C];
                    use_prev_reg <= 1'b0;
                    ret_reg      <= ST_SR_CHK;
                    state_reg    <= ST_D_X;
                end
                ST_SR_CHK: begin
                    if (k_reg == '0) begin
                        best_reg    <= dist_reg;
                        best_k_reg  <= '0;
                        reached_reg <= dist_reg < SUM_W'(REACHED_SQ_MM);
                    end else if (dist_reg < best_reg) begin
                        best_reg   <= dist_reg;
                        best_k_reg <= k_reg;
                        if (dist_reg < SUM_W'(REACHED_SQ_MM))
                            reached_reg <= 1'b1;
                    end
                    // early stop once on the path and moving away
                    if (k_reg != '0 && reached_reg && dist_reg > best_reg)
                        state_reg <= ST_EX_BEG;
                    else if (CNT_W'(k_reg + CNT_W'(1)) == count_reg)
                        state_reg <= ST_EX_BEG;
                    else begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= ST_SR_RD;
                    end
                end
                ST_EX_BEG: begin
                    k_reg    <= best_k_reg;
                    plen_reg <= '0;
                    if (best_reg <= SUM_W'(th_sq_reg) && flen_reg != '0)
                        state_reg <= ST_EX_RD;
                    else
                        state_reg <= ST_EMPTY;
                end
                ST_EX_RD: state_reg <= ST_EX_LD;
                ST_EX_LD: begin
                    cur_x_reg    <= mem_q_reg[C-1:0];
                    cur_y_reg    <= mem_q_reg[2*C-1:C];
                    use_prev_reg <= 1'b0;
                    ret_reg      <= ST_EX_D1;
                    state_reg    <= ST_D_X;
                end
                ST_EX_D1: begin
                    drob_reg  <= dist_reg;
                    state_reg <= (k_reg != '0 && len_pos) ? ST_EX_PRD : ST_EX_OUT;
                end
                ST_EX_PRD: state_reg <= ST_EX_PLD;
                ST_EX_PLD: begin
                    prev_x_reg   <= mem_q_reg[C-1:0];
                    prev_y_reg   <= mem_q_reg[2*C-1:C];
                    use_prev_reg <= 1'b1;
                    ret_reg      <= ST_EX_D2;
                    state_reg    <= ST_D_X;
                end
                ST_EX_D2: state_reg <= ST_EX_SQ;
                ST_EX_SQ: begin
                    if (sqrt_done) begin
                        plen_reg  <= plen_reg + LEN_W'(sqrt_root);
                        state_reg <= ST_EX_OUT;
                    end
                end
                ST_EX_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        out_x_reg   <= cur_x_reg;
                        out_y_reg   <= cur_y_reg;
                        last_reg    <= !cont;
                        empty_reg   <= 1'b0;
                        k_reg       <= k_reg + CNT_W'(1);
                        state_reg   <= cont ? ST_EX_RD : ST_IDLE;
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        out_x_reg   <= '0;
                        out_y_reg   <= '0;
                        last_reg    <= 1'b1;
                        empty_reg   <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_D_X: begin
                    prod_x_reg <= prod;
                    state_reg  <= ST_D_Y;
                end
                ST_D_Y: begin
                    dist_reg  <= dist_sat;
                    state_reg <= ret_reg;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_y_reg, out_x_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = empty_reg;

endmodule

`default_nettype wire

/* rtl/core/lpw_checker.sv */
// ----------------------------------------------------------------------------
// lpw_checker
// Port-level checks of the local path window extractor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpw_checker #(
    parameter int COORD_BITS = lpw_pkg::COORD_BITS_DEF
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
    input wire logic                              m_tlast,
    input wire logic                              m_tuser
);

    // a stalled result word holds
    `LPW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // empty plan word is the last one and carries a zero point
    `LPW_ASSERT_NOW(a_empty_word, aclk, aresetn, m_tvalid && m_tuser,
        m_tlast && m_tdata == '0)

    // no new input while a plan still owes words
    `LPW_ASSERT_NOW(a_plan_busy, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // reset drops the result valid
    `LPW_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn, !m_tvalid)

endmodule

bind local_path_window_extract lpw_checker #(.COORD_BITS(COORD_BITS)) u_lpw_checker (.*);

`default_nettype wire
